// File: rtl/core/hrlf_pkg.sv
package hrlf_pkg;

  localparam int unsigned NAME_LEN = 16;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] INT_MAX   = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_BLANK  = 2'd1,
    ST_NO_DIGITS = 2'd2,
    ST_OVERFLOW  = 2'd3
  } hrlf_status_t;

  typedef enum logic [3:0] {
    PH_NAME = 4'b0001,
    PH_SKIP = 4'b0010,
    PH_NUM  = 4'b0100,
    PH_DONE = 4'b1000
  } hrlf_phase_t;

  typedef struct packed {
    logic        hdr_end;
    logic [31:0] hdr_len;
    logic        found;
    logic        neg;
    logic [31:0] acc;
    logic        digits;
    logic        ovf;
  } hrlf_snap_t;

  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h43;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h6E;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2D;
      4'd8:    ch = 8'h4C;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6E;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      4'd14:   ch = 8'h3A;
      default: ch = 8'h20;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/core/http_request_length_framer_top.sv
// A result goes from the input register via the snapshot to the output register.
// Throughput: one byte per cycle, but a last byte stalls while the snapshot register
// is full and cannot unload; each register holds one item, so bytes keep flowing
// while a finished result waits. Reset: rst_n is synchronous, active low; it empties
// all stages and clears the scan state to the start of a new request buffer.
module http_request_length_framer_top
  import hrlf_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [31:0] total_length, [33:32] status, [39:34] zero
);

  logic        in_vld_r, in_vld_nxt;
  logic [7:0]  in_data_r;
  logic        in_last_r;
  logic        fin_vld_r, fin_vld_nxt;
  hrlf_snap_t  fin_r, snap;
  logic        out_vld_r, out_vld_nxt;
  logic [31:0] total_r, total_c;
  hrlf_status_t status_r, status_c;

  logic        in_acc, in_adv, step, fin_rdy, out_rdy, out_load;
  logic [32:0] val33, sum33;

  always_comb begin
    out_rdy  = !out_vld_r || out_tready;
    fin_rdy  = !fin_vld_r || out_rdy;
    in_adv   = !in_last_r || fin_rdy;
    step     = in_vld_r && in_adv;
    in_tready = !in_vld_r || in_adv;
    in_acc   = in_tvalid && in_tready;
    out_load = fin_vld_r && out_rdy;
  end

  hrlf_scan #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .data_byte(in_data_r),
    .last     (in_last_r),
    .snap     (snap)
  );

  always_comb begin
    val33 = fin_r.neg ? (33'd0 - {1'b0, fin_r.acc}) : {1'b0, fin_r.acc};
    sum33 = {1'b0, fin_r.hdr_len} + val33;
    total_c  = fin_r.hdr_len;
    status_c = ST_OK;
    if (!fin_r.hdr_end) begin
      total_c  = '0;
      status_c = ST_NO_BLANK;
    end else if (fin_r.hdr_len[31]) begin
      total_c  = INT_MAX;
      status_c = ST_OVERFLOW;
    end else if (!fin_r.found) begin
      status_c = ST_OK;
    end else if (!fin_r.digits) begin
      status_c = ST_NO_DIGITS;
    end else if (fin_r.ovf || (!fin_r.neg && fin_r.acc[31])) begin
      status_c = ST_OVERFLOW;
    end else if (sum33[32] != sum33[31]) begin
      status_c = ST_OVERFLOW;
    end else begin
      total_c = sum33[31:0];
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_acc) begin
      in_vld_nxt = 1'b1;
    end else if (step) begin
      in_vld_nxt = 1'b0;
    end
    fin_vld_nxt = fin_vld_r;
    if (step && in_last_r) begin
      fin_vld_nxt = 1'b1;
    end else if (out_load) begin
      fin_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      fin_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      fin_vld_r <= fin_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (step && in_last_r) begin
      fin_r <= snap;
    end
    if (out_load) begin
      total_r  <= total_c;
      status_r <= status_c;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, status_r, total_r};

endmodule

// File: rtl/core/hrlf_scan.sv
module hrlf_scan
  import hrlf_pkg::*;
#(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       last,
  output hrlf_snap_t snap
);

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic [1:0]                blk_r, blk_nxt;
  logic                      end_r, end_nxt;
  logic [POSITION_WIDTH-1:0] hl_r, hl_nxt;
  logic [3:0]                nm_r, nm_nxt;
  hrlf_phase_t               ph_r, ph_nxt;
  logic                      neg_r, neg_nxt;
  logic [31:0]               acc_r, acc_nxt;
  logic                      dig_r, dig_nxt;
  logic                      ovf_r, ovf_nxt;

  logic [POSITION_WIDTH-1:0] pos_up, hl_up;
  logic [1:0]                blk_up;
  logic                      end_up;
  logic [3:0]                nm_up;
  hrlf_phase_t               ph_up;
  logic                      neg_up, dig_up, ovf_up;
  logic [31:0]               acc_up;
  logic                      crlf_now, adv, is_blank, is_digit;
  logic [35:0]               mac;

  always_comb begin
    is_blank = data_byte inside {8'h20, [8'h09:8'h0D]};
    is_digit = data_byte inside {[CH_ZERO:CH_NINE]};
    mac      = 36'(acc_r) * 36'd10 + 36'(data_byte - CH_ZERO);
  end

  always_comb begin
    pos_up   = (pos_r != POS_MAX) ? pos_r + POSITION_WIDTH'(1) : POS_MAX;
    blk_up   = blk_r;
    end_up   = end_r;
    hl_up    = hl_r;
    crlf_now = 1'b0;
    adv      = 1'b0;
    if (!end_r) begin
      adv = (blk_r == 2'd0 || blk_r == 2'd2) ? (data_byte == CH_CR) : (data_byte == CH_LF);
      if (adv) begin
        if (blk_r == 2'd3) begin
          end_up = 1'b1;
          hl_up  = (pos_r != POS_MAX) ? pos_r + POSITION_WIDTH'(1) : POS_MAX;
          blk_up = 2'd0;
        end else begin
          blk_up   = blk_r + 2'd1;
          crlf_now = (blk_r == 2'd1);
        end
      end else begin
        blk_up = (data_byte == CH_CR) ? 2'd1 : 2'd0;
      end
    end
  end

  always_comb begin
    ph_up  = ph_r;
    nm_up  = nm_r;
    neg_up = neg_r;
    acc_up = acc_r;
    dig_up = dig_r;
    ovf_up = ovf_r;
    case (ph_r)
      PH_SKIP: begin
        if (crlf_now) begin
          ph_up = PH_DONE;
        end else if (is_blank) begin
          ph_up = PH_SKIP;
        end else if (data_byte == CH_PLUS || data_byte == CH_MINUS) begin
          neg_up = (data_byte == CH_MINUS);
          ph_up  = PH_NUM;
        end else if (is_digit) begin
          dig_up = 1'b1;
          if (ovf_r || mac > 36'(MAG_LIMIT)) begin
            ovf_up = 1'b1;
            acc_up = MAG_LIMIT;
          end else begin
            acc_up = mac[31:0];
          end
          ph_up = PH_NUM;
        end else begin
          ph_up = PH_DONE;
        end
      end
      PH_NUM: begin
        if (is_digit) begin
          dig_up = 1'b1;
          if (ovf_r || mac > 36'(MAG_LIMIT)) begin
            ovf_up = 1'b1;
            acc_up = MAG_LIMIT;
          end else begin
            acc_up = mac[31:0];
          end
        end else begin
          ph_up = PH_DONE;
        end
      end
      PH_NAME: begin
        if (!end_r) begin
          if (data_byte == name_char(nm_r)) begin
            if (nm_r == 4'(NAME_LEN - 1)) begin
              ph_up = PH_SKIP;
              nm_up = 4'd0;
            end else begin
              nm_up = nm_r + 4'd1;
            end
          end else begin
            nm_up = (data_byte == name_char(4'd0)) ? 4'd1 : 4'd0;
          end
        end
      end
      default: begin
        ph_up = ph_r;
      end
    endcase
  end

  always_comb begin
    snap.hdr_end = end_up;
    snap.hdr_len = 32'(hl_up);
    snap.found   = (ph_up != PH_NAME);
    snap.neg     = neg_up;
    snap.acc     = acc_up;
    snap.digits  = dig_up;
    snap.ovf     = ovf_up;
  end

  always_comb begin
    pos_nxt = pos_r;
    blk_nxt = blk_r;
    end_nxt = end_r;
    hl_nxt  = hl_r;
    nm_nxt  = nm_r;
    ph_nxt  = ph_r;
    neg_nxt = neg_r;
    acc_nxt = acc_r;
    dig_nxt = dig_r;
    ovf_nxt = ovf_r;
    if (step) begin
      if (last) begin
        pos_nxt = '0;
        blk_nxt = '0;
        end_nxt = 1'b0;
        hl_nxt  = '0;
        nm_nxt  = '0;
        ph_nxt  = PH_NAME;
        neg_nxt = 1'b0;
        acc_nxt = '0;
        dig_nxt = 1'b0;
        ovf_nxt = 1'b0;
      end else begin
        pos_nxt = pos_up;
        blk_nxt = blk_up;
        end_nxt = end_up;
        hl_nxt  = hl_up;
        nm_nxt  = nm_up;
        ph_nxt  = ph_up;
        neg_nxt = neg_up;
        acc_nxt = acc_up;
        dig_nxt = dig_up;
        ovf_nxt = ovf_up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      blk_r <= '0;
      end_r <= 1'b0;
      hl_r  <= '0;
      nm_r  <= '0;
      ph_r  <= PH_NAME;
      neg_r <= 1'b0;
      acc_r <= '0;
      dig_r <= 1'b0;
      ovf_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      blk_r <= blk_nxt;
      end_r <= end_nxt;
      hl_r  <= hl_nxt;
      nm_r  <= nm_nxt;
      ph_r  <= ph_nxt;
      neg_r <= neg_nxt;
      acc_r <= acc_nxt;
      dig_r <= dig_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// File: rtl/core/hrlf_checker.sv
module hrlf_checker
  import hrlf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:34] == 6'd0)
    else $error("padding bits set");

  a_no_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33:32] == ST_NO_BLANK |-> out_tdata[31:0] == 32'd0)
    else $error("nonzero length without blank line");

endmodule

bind http_request_length_framer_top hrlf_checker u_hrlf_checker (.*);

// File: test/tb.sv
module tb
  import hrlf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 3;
  localparam string CL_NAME = "Content-Length: ";
  localparam string BLANKS = " \011\012\013\014\015";
  localparam string NOISE = "Host:a-/ 1C\015\012e";

  typedef struct packed {
    logic [31:0]  total;
    hrlf_status_t status;
  } framed_length_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  framed_length_t expected_lengths[$];
  logic [7:0]     req_bytes[$];
  int             fail_count = 0;
  int             bytes_sent = 0;
  int             buffers_sent = 0;
  bit             src_gaps = 1'b1;
  bit             sink_stall = 1'b1;
  int             sink_hold = 0;

  logic [31:0]  pos_q;
  logic [1:0]   blank_q;
  logic         hdr_seen_q;
  logic [31:0]  hdr_len_q;
  int unsigned  name_q;
  hrlf_phase_t  phase_q;
  logic         neg_q;
  logic [31:0]  acc_q;
  logic         dig_q;
  logic         ovf_q;

  http_request_length_framer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task reset_scan();
    pos_q = '0;
    blank_q = '0;
    hdr_seen_q = 1'b0;
    hdr_len_q = '0;
    name_q = 0;
    phase_q = PH_NAME;
    neg_q = 1'b0;
    acc_q = '0;
    dig_q = 1'b0;
    ovf_q = 1'b0;
  endtask

  task add_digit(input logic [7:0] c);
    logic [63:0] nxt;
    nxt = 64'(acc_q) * 10 + 64'(c - CH_ZERO);
    dig_q = 1'b1;
    if (ovf_q || nxt > 64'h8000_0000) begin
      ovf_q = 1'b1;
      acc_q = 32'h8000_0000;
    end else begin
      acc_q = nxt[31:0];
    end
  endtask

  task scan_byte(input logic [7:0] c, input logic is_last);
    logic           crlf_now;
    logic           was_end;
    logic           adv;
    longint         v;
    longint         sum;
    framed_length_t res;
    crlf_now = 1'b0;
    was_end = hdr_seen_q;
    if (!was_end) begin
      adv = (blank_q == 2'd0 || blank_q == 2'd2) ? (c == CH_CR) : (c == CH_LF);
      if (adv) begin
        if (blank_q == 2'd3) begin
          hdr_seen_q = 1'b1;
          hdr_len_q = (pos_q != '1) ? pos_q + 1 : pos_q;
          blank_q = 2'd0;
        end else begin
          crlf_now = (blank_q == 2'd1);
          blank_q = blank_q + 2'd1;
        end
      end else begin
        blank_q = (c == CH_CR) ? 2'd1 : 2'd0;
      end
    end
    case (phase_q)
      PH_SKIP: begin
        if (crlf_now) begin
          phase_q = PH_DONE;
        end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg_q = (c == CH_MINUS);
          phase_q = PH_NUM;
        end else if (is_digit(c)) begin
          add_digit(c);
          phase_q = PH_NUM;
        end else begin
          phase_q = PH_DONE;
        end
      end
      PH_NUM: begin
        if (is_digit(c)) add_digit(c);
        else phase_q = PH_DONE;
      end
      PH_NAME: begin
        if (!was_end) begin
          if (name_q < 16 && c == CL_NAME[name_q]) begin
            name_q++;
            if (name_q == 16) begin
              phase_q = PH_SKIP;
              name_q = 0;
            end
          end else begin
            name_q = (c == CL_NAME[0]) ? 1 : 0;
          end
        end
      end
      default: ;
    endcase
    if (pos_q != '1) pos_q = pos_q + 1;
    if (is_last) begin
      if (!hdr_seen_q) begin
        res.total = '0;
        res.status = ST_NO_BLANK;
      end else if (hdr_len_q > 32'h7FFF_FFFF) begin
        res.total = 32'h7FFF_FFFF;
        res.status = ST_OVERFLOW;
      end else begin
        res.total = hdr_len_q;
        res.status = ST_OK;
        if (phase_q == PH_NAME) begin
        end else if (!dig_q) begin
          res.status = ST_NO_DIGITS;
        end else if (ovf_q || (!neg_q && acc_q > 32'h7FFF_FFFF)) begin
          res.status = ST_OVERFLOW;
        end else begin
          v = longint'(acc_q);
          if (neg_q) v = -v;
          sum = longint'(hdr_len_q) + v;
          if (sum > 64'sd2147483647 || sum < -64'sd2147483648) res.status = ST_OVERFLOW;
          else res.total = sum[31:0];
        end
      end
      expected_lengths.push_back(res);
      reset_scan();
    end
  endtask

  always @(posedge clk) begin : check_out
    framed_length_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_lengths.size() == 0) begin
        $display("%0t unexpected item: expected none, got total_length %0d status %0d",
                 $time, $signed(out_tdata[31:0]), out_tdata[33:32]);
        fail_count++;
      end else begin
        want = expected_lengths.pop_front();
        if (out_tdata[31:0] !== want.total) begin
          $display("%0t total_length: expected %0d, got %0d", $time,
                   $signed(want.total), $signed(out_tdata[31:0]));
          fail_count++;
        end
        if (out_tdata[33:32] !== want.status) begin
          $display("%0t status: expected %0d, got %0d", $time, want.status,
                   out_tdata[33:32]);
          fail_count++;
        end
        if (out_tdata[39:34] !== 6'd0) begin
          $display("%0t padding: expected 0, got %0h", $time, out_tdata[39:34]);
          fail_count++;
        end
      end
    end
  end

  initial begin : sink
    int k;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        k = sink_hold;
        sink_hold = 0;
        repeat (k) @(posedge clk);
      end else if (sink_stall && $urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task send_byte(input logic [7:0] b, input logic is_last);
    int g;
    g = src_gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scan_byte(b, is_last);
    bytes_sent++;
  endtask

  task send_request();
    for (int i = 0; i < req_bytes.size(); i++) begin
      send_byte(req_bytes[i], i == req_bytes.size() - 1);
    end
    buffers_sent++;
  endtask

  task put_text(input string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endtask

  task send_text(input string s);
    req_bytes.delete();
    put_text(s);
    send_request();
  endtask

  // idle the input, then hold until every result is back
  task drain();
    in_tvalid <= 1'b0;
    while (expected_lengths.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task put_noise_line();
    repeat ($urandom_range(1, 8)) req_bytes.push_back(NOISE[$urandom_range(0, NOISE.len() - 1)]);
    put_text("\015\012");
  endtask

  task put_length_line();
    string digits;
    if ($urandom_range(0, 9) == 0) put_text(CL_NAME.substr(0, $urandom_range(0, 14)));
    put_text(CL_NAME);
    repeat ($urandom_range(0, 2)) req_bytes.push_back(BLANKS[$urandom_range(0, 5)]);
    case ($urandom_range(0, 5))
      0: put_text("+");
      1: put_text("-");
      default: ;
    endcase
    digits = "";
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        case ($urandom_range(0, 3))
          0: digits = "2147483647";
          1: digits = "2147483648";
          2: digits = "2147483600";
          default: digits = "4294967295";
        endcase
      end
      2, 3: repeat ($urandom_range(1, 12)) digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
      default: digits = $sformatf("%0d", $urandom_range(0, 5000));
    endcase
    put_text(digits);
    if ($urandom_range(0, 4) == 0) put_text(" 7x");
    put_text("\015\012");
  endtask

  task build_request();
    int kind;
    kind = $urandom_range(0, 99);
    req_bytes.delete();
    if (kind < 10) begin
      repeat ($urandom_range(1, 24)) begin
        case ($urandom_range(0, 3))
          0: req_bytes.push_back(CH_CR);
          1: req_bytes.push_back(CH_LF);
          default: req_bytes.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else begin
      if ($urandom_range(0, 1)) put_text("GET /\015\012");
      if ($urandom_range(0, 1)) put_noise_line();
      if (kind >= 25) put_length_line();
      if ($urandom_range(0, 2) == 0) put_noise_line();
      if (kind >= 80) put_length_line();
      if ($urandom_range(0, 9) != 0) put_text("\015\012");
      if ($urandom_range(0, 7) == 0) put_text("Content-Length: 3");
      repeat ($urandom_range(0, 12)) req_bytes.push_back(8'($urandom_range(0, 255)));
      if (req_bytes.size() == 0) req_bytes.push_back(8'h41);
      if ($urandom_range(0, 19) == 0) begin
        kind = $urandom_range(1, req_bytes.size());
        while (req_bytes.size() > kind) void'(req_bytes.pop_back());
      end
    end
  endtask

  task test_directed();
    send_text("A");
    send_text("\015\012\015\012");
    send_text("GET / HTTP/1.1\015\012Content-Length: 12\015\012\015\012ab");
    send_text("Content-Length: \011 -3\015\012\015\012");
    send_text("Content-Length: +7\015\012\015\012");
    send_text("Content-Length: \013\014\012\01519\015\012\015\012");
    send_text("Content-Length: \015\012\015\012");
    send_text("Content-Length: -x\015\012\015\012");
    send_text("Content-Length: 2147483648\015\012\015\012");
    send_text("Content-Length: -2147483648\015\012\015\012");
    send_text("Content-Length: 2147483647\015\012\015\012");
    send_text("Content-Length: 99999999999\015\012\015\012");
    send_text("\015\012\015\012Content-Length: 5");
    send_text("CContent-Length: 4 2\015\012\015\012");
    send_text("content-length: 5\015\012\015\012");
    send_text("Content-Length: 8\015\012");
    send_text("\015\015\012\015\012");
    drain();
  endtask

  task test_backpressure();
    src_gaps = 1'b0;
    sink_hold = 400;
    repeat (15) begin
      req_bytes.delete();
      put_text("\015\012\015\012");
      repeat ($urandom_range(0, 3)) req_bytes.push_back(8'($urandom_range(0, 255)));
      send_request();
    end
    drain();
    src_gaps = 1'b1;
  endtask

  task test_random();
    while (bytes_sent < 1700 || buffers_sent < 60) begin
      if ($urandom_range(0, 19) == 0) src_gaps = !src_gaps;
      if ($urandom_range(0, 19) == 0) sink_stall = !sink_stall;
      build_request();
      send_request();
    end
    drain();
  endtask

  initial begin
    reset_scan();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: http_request_length_framer_top.f
rtl/core/hrlf_pkg.sv
rtl/core/hrlf_scan.sv
rtl/core/http_request_length_framer_top.sv
rtl/core/hrlf_checker.sv
test/tb.sv
